// ----- rtl/pwow_pkg.sv -----
// Shared types and constants for the pulse-width one-wire writer.
// Used by every RTL file of the block but pwow_fifo; depends on nothing.
package pwow_pkg;

  localparam int ADDR_BITS = 8;
  localparam int IDX_IN_W  = 3;
  localparam int VAL_IN_W  = 8;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TICKS      = 3'd4;

  localparam logic [ADDR_BITS-1:0] RST_DEVICE_ADDRESS = 8'h00;
  localparam logic [TICK_W-1:0]    RST_SHORT_TICKS    = 16'd4;
  localparam logic [TICK_W-1:0]    RST_LONG_TICKS     = 16'd12;
  localparam logic [TICK_W-1:0]    RST_START_TICKS    = 16'd16;
  localparam logic [TICK_W-1:0]    RST_END_TICKS      = 16'd400;

  typedef struct packed {
    logic [ADDR_BITS-1:0] device_address;
    logic [TICK_W-1:0]    short_ticks;
    logic [TICK_W-1:0]    long_ticks;
    logic [TICK_W-1:0]    start_ticks;
    logic [TICK_W-1:0]    end_ticks;
  } cfg_t;

  typedef struct packed {
    logic              line_level;
    logic [TICK_W-1:0] hold_ticks;
    logic              last_segment;
  } seg_t;

endpackage

// ----- rtl/pwow_if.sv -----
// Valid/ready channel interfaces for the request and segment streams.
// Depends on pwow_pkg for the field widths.
interface pwow_in_if;
  logic                           valid;
  logic                           ready;
  logic [pwow_pkg::IDX_IN_W-1:0]  reg_index;
  logic [pwow_pkg::VAL_IN_W-1:0]  write_value;

  modport source (output valid, output reg_index, output write_value, input ready);
  modport sink   (input valid, input reg_index, input write_value, output ready);
endinterface

interface pwow_out_if;
  logic                         valid;
  logic                         ready;
  logic                         line_level;
  logic [pwow_pkg::TICK_W-1:0]  hold_ticks;
  logic                         last_segment;

  modport source (output valid, output line_level, output hold_ticks,
                  output last_segment, input ready);
  modport sink   (input valid, input line_level, input hold_ticks,
                  input last_segment, output ready);
endinterface

// ----- rtl/pwow_cfg.sv -----
// Configuration register file: device address and the four timing values.
// Depends on pwow_pkg for register indexes, reset values and cfg_t.
module pwow_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pwow_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pwow_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  output pwow_pkg::cfg_t                     cfg
);

  pwow_pkg::cfg_t cfg_r;
  pwow_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pwow_pkg::CFG_DEVICE_ADDRESS:
          cfg_nxt.device_address = cfg_wdata[pwow_pkg::ADDR_BITS-1:0];
        pwow_pkg::CFG_SHORT_TICKS: cfg_nxt.short_ticks = cfg_wdata;
        pwow_pkg::CFG_LONG_TICKS:  cfg_nxt.long_ticks  = cfg_wdata;
        pwow_pkg::CFG_START_TICKS: cfg_nxt.start_ticks = cfg_wdata;
        pwow_pkg::CFG_END_TICKS:   cfg_nxt.end_ticks   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= pwow_pkg::RST_DEVICE_ADDRESS;
      cfg_r.short_ticks    <= pwow_pkg::RST_SHORT_TICKS;
      cfg_r.long_ticks     <= pwow_pkg::RST_LONG_TICKS;
      cfg_r.start_ticks    <= pwow_pkg::RST_START_TICKS;
      cfg_r.end_ticks      <= pwow_pkg::RST_END_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/pwow_front.sv -----
// Request front end: accepts write requests and packs address, index and
// data into one frame word for the queue. Depends on pwow_pkg and pwow_if.
module pwow_front #(
  parameter int INDEX_BITS = 3,
  parameter int DATA_BITS  = 8,
  parameter int FRAME_BITS = pwow_pkg::ADDR_BITS + INDEX_BITS + DATA_BITS
) (
  pwow_in_if.sink                   in_if,
  input  logic [pwow_pkg::ADDR_BITS-1:0] device_address,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [FRAME_BITS-1:0]     q_wdata
);

  logic [INDEX_BITS-1:0] idx_f;
  logic [DATA_BITS-1:0]  val_f;

  // Size casts zero-extend when the field is wider than the request and
  // drop high bits when it is narrower.
  assign idx_f = INDEX_BITS'(in_if.reg_index);
  assign val_f = DATA_BITS'(in_if.write_value);

  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;
  assign q_wdata     = {device_address, idx_f, val_f};

endmodule

// ----- rtl/pwow_fifo.sv -----
// Small register FIFO that decouples the request front end from the
// segment sequencer. Self-contained; DEPTH must be a power of two.
module pwow_fifo #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/pwow_back.sv -----
// Segment sequencer: walks one frame word from the queue and emits one line
// segment per cycle unless stalled, into an output register. Depends on pwow_pkg, pwow_if.
module pwow_back #(
  parameter int FRAME_BITS = 19
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pwow_pkg::cfg_t        cfg,
  input  logic                  q_not_empty,
  input  logic [FRAME_BITS-1:0] q_rdata,
  output logic                  q_pop,
  pwow_out_if.source            out_if
);

  localparam int NSEG  = 2 * FRAME_BITS + 3;
  localparam int SEG_W = $clog2(NSEG);
  localparam logic [SEG_W-1:0] SEG_TAIL_LOW = SEG_W'(2 * FRAME_BITS + 1);
  localparam logic [SEG_W-1:0] SEG_LAST     = SEG_W'(2 * FRAME_BITS + 2);

  logic                  busy_r, busy_nxt;
  logic [SEG_W-1:0]      seg_r, seg_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  out_valid_r, out_valid_nxt;
  pwow_pkg::seg_t        out_seg_r, out_seg_nxt;

  logic           emit;
  logic           load;
  logic           is_start;
  logic           is_last;
  logic           cur_bit;
  pwow_pkg::seg_t cur_seg;

  assign is_start = (seg_r == '0);
  assign is_last  = (seg_r == SEG_LAST);
  assign cur_bit  = frame_r[FRAME_BITS-1];

  // Bit segments come in pairs: odd counts are the low phase, even the high.
  // A 0 bit holds the low phase long, a 1 bit holds the high phase long.
  always_comb begin
    cur_seg.last_segment = 1'b0;
    if (is_start) begin
      cur_seg.line_level = 1'b1;
      cur_seg.hold_ticks = cfg.start_ticks;
    end else if (seg_r == SEG_TAIL_LOW) begin
      cur_seg.line_level = 1'b0;
      cur_seg.hold_ticks = cfg.short_ticks;
    end else if (is_last) begin
      cur_seg.line_level   = 1'b1;
      cur_seg.hold_ticks   = cfg.end_ticks;
      cur_seg.last_segment = 1'b1;
    end else begin
      cur_seg.line_level = !seg_r[0];
      if (cur_bit != seg_r[0]) begin
        cur_seg.hold_ticks = cfg.long_ticks;
      end else begin
        cur_seg.hold_ticks = cfg.short_ticks;
      end
    end
  end

  assign emit  = busy_r && (!out_valid_r || out_if.ready);
  assign load  = q_not_empty && (!busy_r || (emit && is_last));
  assign q_pop = load;

  always_comb begin
    busy_nxt      = busy_r;
    seg_nxt       = seg_r;
    frame_nxt     = frame_r;
    out_valid_nxt = out_valid_r;
    out_seg_nxt   = out_seg_r;

    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_seg_nxt   = cur_seg;
      seg_nxt       = seg_r + 1'b1;
      // The high phase closes a bit, so the next bit moves up to the top.
      if (!is_start && !seg_r[0]) begin
        frame_nxt = frame_r << 1;
      end
      if (is_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt  = 1'b1;
      seg_nxt   = '0;
      frame_nxt = q_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r   <= frame_nxt;
    out_seg_r <= out_seg_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.line_level   = out_seg_r.line_level;
  assign out_if.hold_ticks   = out_seg_r.hold_ticks;
  assign out_if.last_segment = out_seg_r.last_segment;

endmodule

// ----- rtl/pulse_width_one_wire_writer.sv -----
// Top level of the pulse-width one-wire register writer.
// Depends on pwow_pkg, pwow_if, pwow_cfg, pwow_front, pwow_fifo, pwow_back.
//
//   channel  direction  handshake      payload
//   in_if    in         valid/ready    reg_index[2:0], write_value[7:0]
//   out_if   out        valid/ready    line_level, hold_ticks[15:0], last_segment
//   cfg_*    in         cfg_we only    cfg_index[2:0], cfg_wdata[15:0]
//
// Each request yields 2*(8+INDEX_BITS+DATA_BITS)+3 segments (41 by default),
// one per cycle from the sequencer counter while the sink does not stall.
// Requests wait in a two-entry queue, and a queued frame is loaded in the
// same cycle as the last segment of the previous one is emitted.
// Synchronous active-low reset clears the control state and loads the
// default timing registers. A stalled output holds its segment in place.
module pulse_width_one_wire_writer #(
  parameter int INDEX_BITS = 3,
  parameter int DATA_BITS  = 8,
  parameter int Q_DEPTH    = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pwow_in_if.sink                        in_if,
  pwow_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [pwow_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwow_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int FRAME_BITS = pwow_pkg::ADDR_BITS + INDEX_BITS + DATA_BITS;

  pwow_pkg::cfg_t        cfg;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_not_empty;
  logic [FRAME_BITS-1:0] q_wdata;
  logic [FRAME_BITS-1:0] q_rdata;

  pwow_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pwow_front #(
    .INDEX_BITS (INDEX_BITS),
    .DATA_BITS  (DATA_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_front (
    .in_if          (in_if),
    .device_address (cfg.device_address),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  pwow_fifo #(
    .WIDTH (FRAME_BITS),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  pwow_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_if      (out_if)
  );

endmodule

// ----- sim/pulse_width_one_wire_writer_test.sv -----
// Self-checking testbench for pulse_width_one_wire_writer: sends register write requests,
// changes the timing registers between phases and checks every line segment in order.
// Depends on pwow_pkg, the channel interfaces in pwow_if and the writer RTL.
module pulse_width_one_wire_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BITS        = pwow_pkg::ADDR_BITS + pwow_pkg::IDX_IN_W +
                                     pwow_pkg::VAL_IN_W;
  localparam int SETTLE_CYCLES     = 45;
  localparam int RANDOM_ITEMS      = 320;
  localparam int ITEMS_PER_SETTING = 40;
  localparam int NO_TYPED          = -1;
  localparam int TICK_MAX          = (1 << pwow_pkg::TICK_W) - 1;
  localparam int DIRECTED_ROWS     = 30;

  // Register indexes past the last timing register decode to nothing.
  localparam logic [pwow_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
    pwow_pkg::CFG_END_TICKS + 1'b1;
  localparam logic [pwow_pkg::CFG_IDX_W-1:0] CFG_LAST_INDEX   = '1;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [pwow_pkg::CFG_IDX_W-1:0] cfg_sel;
    logic [pwow_pkg::CFG_DAT_W-1:0] cfg_val;
    logic [pwow_pkg::IDX_IN_W-1:0]  reg_index;
    logic [pwow_pkg::VAL_IN_W-1:0]  write_value;
    int                             start_hold;
    int                             end_hold;
  } row_t;

  typedef struct packed {
    int start_hold;
    int end_hold;
  } typed_t;

  typedef pwow_pkg::seg_t seg_q_t[$];

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [pwow_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pwow_pkg::CFG_DAT_W-1:0] cfg_wdata;

  pwow_in_if  req_ch ();
  pwow_out_if seg_ch ();

  pulse_width_one_wire_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_ch),
    .out_if    (seg_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Typed start and end holds are checked in place of the prediction for those rows.
  row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd0, 8'h00, 16, 400},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd7, 8'hff, 16, 400},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd5, 8'ha5, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h00ff, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_SHORT_TICKS, 16'h0000, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_LONG_TICKS, 16'h0000, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_START_TICKS, 16'h0000, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_END_TICKS, 16'h0000, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd0, 8'h00, 0, 0},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd7, 8'hff, 0, 0},
    '{ROW_WRITE, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_SHORT_TICKS, 16'hffff, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_LONG_TICKS, 16'hffff, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_START_TICKS, 16'hffff, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_END_TICKS, 16'hffff, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd7, 8'hff, TICK_MAX, TICK_MAX},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd2, 8'h5a, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, CFG_FIRST_UNUSED, 16'h0000, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, CFG_LAST_INDEX, 16'h0000, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd3, 8'h81, TICK_MAX, TICK_MAX},
    '{ROW_WRITE, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0096, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_SHORT_TICKS, 16'h0001, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_LONG_TICKS, 16'h0002, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_START_TICKS, 16'h0003, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_WRITE, pwow_pkg::CFG_END_TICKS, 16'h0005, 3'd0, 8'h00, NO_TYPED, NO_TYPED},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd1, 8'h01, NO_TYPED, NO_TYPED},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd6, 8'h80, NO_TYPED, NO_TYPED},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd4, 8'h7f, NO_TYPED, NO_TYPED},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd0, 8'hff, NO_TYPED, NO_TYPED},
    '{ROW_REQUEST, pwow_pkg::CFG_DEVICE_ADDRESS, 16'h0000, 3'd7, 8'h00, NO_TYPED, NO_TYPED}
  };

  pwow_pkg::seg_t segs_due [$];
  typed_t         typed_due [$];
  pwow_pkg::cfg_t timing;
  bit             tx_calm;
  int             err_count;
  int             reqs_taken;
  int             segs_seen;
  int             writes_done;
  int             settings_used;

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [pwow_pkg::TICK_W-1:0] pick_ticks();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return pwow_pkg::TICK_W'($urandom_range(1, 20));
      default: return pwow_pkg::TICK_W'($urandom());
    endcase
  endfunction

  // Start segment, then address, index and value MSB first, two segments per bit,
  // then the closing short low and the flagged end segment.
  function automatic seg_q_t frame_for_write(pwow_pkg::cfg_t c,
                                             logic [pwow_pkg::IDX_IN_W-1:0] idx,
                                             logic [pwow_pkg::VAL_IN_W-1:0] val);
    logic [FRAME_BITS-1:0] word;
    seg_q_t frame;
    word = {c.device_address, idx, val};
    frame.push_back('{1'b1, c.start_ticks, 1'b0});
    for (int i = FRAME_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        frame.push_back('{1'b0, c.short_ticks, 1'b0});
        frame.push_back('{1'b1, c.long_ticks, 1'b0});
      end else begin
        frame.push_back('{1'b0, c.long_ticks, 1'b0});
        frame.push_back('{1'b1, c.short_ticks, 1'b0});
      end
    end
    frame.push_back('{1'b0, c.short_ticks, 1'b0});
    frame.push_back('{1'b1, c.end_ticks, 1'b1});
    return frame;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("%t segment %0d: %s", $realtime, segs_seen, msg);
  endtask

  // Register writes, request transfers and segment transfers are all seen at the
  // same edge here, so the order of prediction and checking is fixed.
  always @(posedge clk) begin : segment_check
    seg_q_t         frame;
    typed_t         hint;
    pwow_pkg::seg_t want;
    if (!rst_n) begin
      timing = '{pwow_pkg::RST_DEVICE_ADDRESS, pwow_pkg::RST_SHORT_TICKS,
                 pwow_pkg::RST_LONG_TICKS, pwow_pkg::RST_START_TICKS,
                 pwow_pkg::RST_END_TICKS};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pwow_pkg::CFG_DEVICE_ADDRESS:
            timing.device_address = cfg_wdata[pwow_pkg::ADDR_BITS-1:0];
          pwow_pkg::CFG_SHORT_TICKS: timing.short_ticks = cfg_wdata;
          pwow_pkg::CFG_LONG_TICKS:  timing.long_ticks = cfg_wdata;
          pwow_pkg::CFG_START_TICKS: timing.start_ticks = cfg_wdata;
          pwow_pkg::CFG_END_TICKS:   timing.end_ticks = cfg_wdata;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready) begin
        frame = frame_for_write(timing, req_ch.reg_index, req_ch.write_value);
        hint = typed_due.pop_front();
        if (hint.start_hold != NO_TYPED)
          frame[0].hold_ticks = pwow_pkg::TICK_W'(hint.start_hold);
        if (hint.end_hold != NO_TYPED)
          frame[frame.size() - 1].hold_ticks = pwow_pkg::TICK_W'(hint.end_hold);
        foreach (frame[i]) segs_due.push_back(frame[i]);
        reqs_taken++;
      end
      if (seg_ch.valid && seg_ch.ready) begin
        if (segs_due.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer, level %0b hold %0d last %0b",
                                    seg_ch.line_level, seg_ch.hold_ticks,
                                    seg_ch.last_segment));
        end else begin
          want = segs_due.pop_front();
          if (seg_ch.line_level !== want.line_level)
            report_mismatch($sformatf("line_level %b, want %b",
                                      seg_ch.line_level, want.line_level));
          if (seg_ch.hold_ticks !== want.hold_ticks)
            report_mismatch($sformatf("hold_ticks %0d, want %0d",
                                      seg_ch.hold_ticks, want.hold_ticks));
          if (seg_ch.last_segment !== want.last_segment)
            report_mismatch($sformatf("last_segment %b, want %b",
                                      seg_ch.last_segment, want.last_segment));
        end
        segs_seen++;
      end
    end
  end

  initial begin : sink_pacing
    int stall_left;
    int calm_left;
    int g;
    bit rx_calm;
    seg_ch.ready <= 1'b0;
    stall_left = 0;
    calm_left = 0;
    rx_calm = 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(200, 600);
      end
      calm_left--;
      if (stall_left > 0) begin
        stall_left--;
        seg_ch.ready <= 1'b0;
      end else begin
        g = pick_gap(rx_calm);
        seg_ch.ready <= (g == 0);
        stall_left = (g > 0) ? g - 1 : 0;
      end
    end
  end

  task automatic send_request(logic [pwow_pkg::IDX_IN_W-1:0] idx,
                              logic [pwow_pkg::VAL_IN_W-1:0] val,
                              int start_hold, int end_hold);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_due.push_back('{start_hold, end_hold});
    req_ch.valid <= 1'b1;
    req_ch.reg_index <= idx;
    req_ch.write_value <= val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Holds off new requests until every predicted segment has been transferred.
  task automatic wait_idle();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    @(posedge clk);
    while (segs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [pwow_pkg::CFG_IDX_W-1:0] sel,
                           logic [pwow_pkg::CFG_DAT_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    writes_done++;
  endtask

  task automatic random_setting();
    logic [pwow_pkg::ADDR_BITS-1:0] addr;
    wait_idle();
    case ($urandom_range(0, 3))
      0: addr = '0;
      1: addr = '1;
      default: addr = pwow_pkg::ADDR_BITS'($urandom());
    endcase
    if ($urandom_range(0, 2) != 0)
      write_reg(pwow_pkg::CFG_DEVICE_ADDRESS, pwow_pkg::CFG_DAT_W'(addr));
    if ($urandom_range(0, 2) != 0) write_reg(pwow_pkg::CFG_SHORT_TICKS, pick_ticks());
    if ($urandom_range(0, 2) != 0) write_reg(pwow_pkg::CFG_LONG_TICKS, pick_ticks());
    if ($urandom_range(0, 2) != 0) write_reg(pwow_pkg::CFG_START_TICKS, pick_ticks());
    if ($urandom_range(0, 2) != 0) write_reg(pwow_pkg::CFG_END_TICKS, pick_ticks());
    if ($urandom_range(0, 4) == 0)
      write_reg(pwow_pkg::CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
                pwow_pkg::CFG_DAT_W'($urandom()));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    row_t row;
    logic [pwow_pkg::IDX_IN_W-1:0] idx;
    logic [pwow_pkg::VAL_IN_W-1:0] val;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.reg_index <= '0;
    req_ch.write_value <= '0;
    tx_calm = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settings_used = 1;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!cfg_we) begin
          wait_idle();
          settings_used++;
        end
        write_reg(row.cfg_sel, row.cfg_val);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        send_request(row.reg_index, row.write_value, row.start_hold, row.end_hold);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % ITEMS_PER_SETTING == 0) begin
        random_setting();
        tx_calm = ($urandom_range(0, 3) == 0);
      end else if (n % ITEMS_PER_SETTING == ITEMS_PER_SETTING / 2 && $urandom_range(0, 1)) begin
        wait_idle();
      end
      idx = pwow_pkg::IDX_IN_W'($urandom());
      val = pwow_pkg::VAL_IN_W'($urandom());
      case ($urandom_range(0, 9))
        0: val = '0;
        1: val = '1;
        2: idx = '0;
        3: idx = '1;
        default: ;
      endcase
      send_request(idx, val, NO_TYPED, NO_TYPED);
    end

    wait_idle();
    $display("%0d write requests framed into %0d segments, all checked in order.",
             reqs_taken, segs_seen);
    $display("%0d register writes spread over %0d timing settings, extremes included.",
             writes_done, settings_used);
    if (err_count == 0) begin
      $display("pulse_width_one_wire_writer_test: done, clean");
    end else begin
      $display("pulse_width_one_wire_writer_test: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("%t timed out with %0d segments still due", $realtime, segs_due.size());
    $display("pulse_width_one_wire_writer_test: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pwow_pkg.sv
rtl/pwow_if.sv
rtl/pwow_cfg.sv
rtl/pwow_front.sv
rtl/pwow_fifo.sv
rtl/pwow_back.sv
rtl/pulse_width_one_wire_writer.sv
sim/pulse_width_one_wire_writer_test.sv
